// ----- src/ckx_pkg.sv -----
package ckx_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0] part;
        logic [7:0] key_byte;
        logic [1:0] verdict;
        logic       end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_pair_t;

    localparam logic [7:0] TAG_SEQ      = 8'h30;
    localparam logic [7:0] TAG_VERSION  = 8'ha0;
    localparam logic [7:0] TAG_OID      = 8'h06;
    localparam logic [7:0] TAG_BITS     = 8'h03;
    localparam logic [7:0] TAG_INT      = 8'h02;
    localparam logic [7:0] EC_UNCOMP    = 8'h04;
    localparam logic [7:0] LEN_MASK     = 8'h7f;
    localparam logic [31:0] EC_BITS_LEN = 32'd66;

    localparam logic [1:0] PART_POINT   = 2'd0;
    localparam logic [1:0] PART_MOD     = 2'd1;
    localparam logic [1:0] PART_EXP     = 2'd2;
    localparam logic [1:0] PART_VERDICT = 2'd3;

    localparam logic [1:0] VERD_P256 = 2'd0;
    localparam logic [1:0] VERD_RSA  = 2'd1;
    localparam logic [1:0] VERD_REJ  = 2'd2;

    localparam int CAND_EC   = 0;
    localparam int CAND_RSA  = 1;
    localparam int CAND_P256 = 2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_EC   = 2'd1;
    localparam logic [1:0] KIND_RSA  = 2'd2;

    function automatic logic [7:0] oid_ec_byte(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h2a;
            4'd1: r = 8'h86;
            4'd2: r = 8'h48;
            4'd3: r = 8'hce;
            4'd4: r = 8'h3d;
            4'd5: r = 8'h02;
            4'd6: r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] oid_rsa_byte(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h2a;
            4'd1: r = 8'h86;
            4'd2: r = 8'h48;
            4'd3: r = 8'h86;
            4'd4: r = 8'hf7;
            4'd5: r = 8'h0d;
            4'd6: r = 8'h01;
            4'd7: r = 8'h01;
            4'd8: r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] oid_p256_byte(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h2a;
            4'd1: r = 8'h86;
            4'd2: r = 8'h48;
            4'd3: r = 8'hce;
            4'd4: r = 8'h3d;
            4'd5: r = 8'h03;
            4'd6: r = 8'h01;
            4'd7: r = 8'h07;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- src/ckx_chan_if.sv -----
interface ckx_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/ckx_parser.sv -----
module ckx_parser #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ckx_pkg::in_item_t item,
    output ckx_pkg::res_pair_t res
);
    import ckx_pkg::*;

    typedef enum logic [4:0] {
        PH_CERT_HDR, PH_TBS_HDR, PH_TBS_FIRST, PH_SKIP_HDR, PH_SKIP_BODY,
        PH_SPKI_HDR, PH_ALGO_HDR, PH_OID_HDR, PH_OID_BODY, PH_PARAM_HDR,
        PH_PARAM_BODY, PH_ALGO_REST, PH_BITS_HDR, PH_BITS_UNUSED, PH_EC_PREFIX,
        PH_EC_POINT, PH_RSA_HDR, PH_N_HDR, PH_N_BODY, PH_E_HDR, PH_E_BODY,
        PH_DONE, PH_FAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] ends_reg [6];
    logic [5:0]  ends_we;
    logic [31:0] elem_reg, elem_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  left_reg, left_next;
    logic [2:0]  skip_reg, skip_next;
    logic [2:0]  flags_reg, flags_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic [1:0]  kind_reg, kind_next;
    logic        first_reg, first_next;
    logic        rej_reg, rej_next;
    logic [1:0]  hstage_reg, hstage_next;

    logic [32:0] nxt, vend, pend;
    logic [7:0]  b;
    logic [6:0]  nb;
    logic [2:0]  sk;
    logic        hdr_done, fault, emit, at_end;
    logic [1:0]  emit_part, verd;

    always_comb
    begin
        b = item.in_byte;
        nxt = {1'b0, pos_reg} + 33'd1;
        at_end = (nxt == {1'b0, elem_reg});
        phase_next = phase_reg;
        pos_next = (&pos_reg) ? pos_reg : pos_reg + 32'd1;
        ends_we = '0;
        elem_next = elem_reg;
        tag_next = tag_reg;
        acc_next = acc_reg;
        left_next = left_reg;
        skip_next = skip_reg;
        flags_next = flags_reg;
        oidx_next = oidx_reg;
        kind_next = kind_reg;
        first_next = first_reg;
        rej_next = rej_reg;
        hstage_next = hstage_reg;
        hdr_done = 1'b0;
        fault = 1'b0;
        emit = 1'b0;
        emit_part = PART_POINT;
        nb = b[6:0] & LEN_MASK[6:0];
        sk = '0;
        vend = '0;
        pend = '0;
        verd = VERD_REJ;

        unique case (phase_reg)
            PH_SKIP_BODY:
            begin
                if (at_end)
                begin
                    sk = (skip_reg != 3'd0) ? skip_reg - 3'd1 : 3'd0;
                    skip_next = sk;
                    phase_next = (sk == 3'd0) ? PH_SPKI_HDR : PH_SKIP_HDR;
                end
            end
            PH_OID_BODY, PH_PARAM_BODY:
            begin
                if (phase_reg == PH_OID_BODY)
                begin
                    if (b != oid_ec_byte(oidx_reg)) flags_next[CAND_EC] = 1'b0;
                    if (b != oid_rsa_byte(oidx_reg)) flags_next[CAND_RSA] = 1'b0;
                end
                else if (b != oid_p256_byte(oidx_reg))
                begin
                    flags_next[CAND_P256] = 1'b0;
                end
                if (oidx_reg != 4'd15) oidx_next = oidx_reg + 4'd1;
                if (at_end)
                begin
                    if (phase_reg == PH_OID_BODY && flags_next[CAND_EC])
                    begin
                        kind_next = KIND_EC;
                        phase_next = PH_PARAM_HDR;
                    end
                    else if ((phase_reg == PH_OID_BODY && flags_next[CAND_RSA]) ||
                             (phase_reg == PH_PARAM_BODY && flags_next[CAND_P256]))
                    begin
                        if (phase_reg == PH_OID_BODY) kind_next = KIND_RSA;
                        elem_next = ends_reg[3];
                        phase_next = (nxt == {1'b0, ends_reg[3]}) ? PH_BITS_HDR : PH_ALGO_REST;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
            end
            PH_ALGO_REST:
            begin
                if (at_end) phase_next = PH_BITS_HDR;
            end
            PH_BITS_UNUSED:
            begin
                if (b != 8'd0) fault = 1'b1;
                else phase_next = (kind_reg == KIND_EC) ? PH_EC_PREFIX : PH_RSA_HDR;
            end
            PH_EC_PREFIX:
            begin
                if (b != EC_UNCOMP) fault = 1'b1;
                else
                begin
                    elem_next = ends_reg[4];
                    phase_next = PH_EC_POINT;
                end
            end
            PH_EC_POINT:
            begin
                emit = 1'b1;
                emit_part = PART_POINT;
                if (at_end) phase_next = PH_DONE;
            end
            PH_N_BODY, PH_E_BODY:
            begin
                emit = !(first_reg && b == 8'd0 && nxt < {1'b0, elem_reg});
                emit_part = (phase_reg == PH_N_BODY) ? PART_MOD : PART_EXP;
                first_next = 1'b0;
                if (at_end) phase_next = (phase_reg == PH_N_BODY) ? PH_E_HDR : PH_DONE;
            end
            PH_DONE, PH_FAIL:
            begin
            end
            default:
            begin
                unique case (hstage_reg)
                    2'd0:
                    begin
                        tag_next = b;
                        hstage_next = 2'd1;
                    end
                    2'd1:
                    begin
                        if (!b[7])
                        begin
                            acc_next = {24'd0, b};
                            hstage_next = 2'd0;
                            hdr_done = 1'b1;
                        end
                        else if (nb == 7'd0 || nb > 7'(MAX_LENGTH_BYTES))
                        begin
                            hstage_next = 2'd0;
                            fault = 1'b1;
                        end
                        else
                        begin
                            acc_next = '0;
                            left_next = nb[2:0];
                            hstage_next = 2'd2;
                        end
                    end
                    default:
                    begin
                        acc_next = {acc_reg[23:0], b};
                        if (left_reg != 3'd0) left_next = left_reg - 3'd1;
                        if (left_next == 3'd0)
                        begin
                            hstage_next = 2'd0;
                            hdr_done = 1'b1;
                        end
                    end
                endcase

                if (hdr_done)
                begin
                    vend = nxt + {1'b0, acc_next};
                    unique case (phase_reg)
                        PH_CERT_HDR: pend = {1'b0, 32'hffff_ffff};
                        PH_TBS_HDR: pend = {1'b0, ends_reg[0]};
                        PH_TBS_FIRST, PH_SKIP_HDR, PH_SPKI_HDR: pend = {1'b0, ends_reg[1]};
                        PH_ALGO_HDR, PH_BITS_HDR: pend = {1'b0, ends_reg[2]};
                        PH_OID_HDR, PH_PARAM_HDR: pend = {1'b0, ends_reg[3]};
                        PH_RSA_HDR: pend = {1'b0, ends_reg[4]};
                        default: pend = {1'b0, ends_reg[5]};
                    endcase
                    if (vend > pend) fault = 1'b1;
                    else
                    begin
                        unique case (phase_reg)
                            PH_CERT_HDR, PH_TBS_HDR, PH_SPKI_HDR, PH_ALGO_HDR, PH_RSA_HDR:
                            begin
                                if (tag_next != TAG_SEQ) fault = 1'b1;
                                else
                                begin
                                    unique case (phase_reg)
                                        PH_CERT_HDR:
                                        begin
                                            ends_we[0] = 1'b1;
                                            phase_next = PH_TBS_HDR;
                                        end
                                        PH_TBS_HDR:
                                        begin
                                            ends_we[1] = 1'b1;
                                            phase_next = PH_TBS_FIRST;
                                        end
                                        PH_SPKI_HDR:
                                        begin
                                            ends_we[2] = 1'b1;
                                            phase_next = PH_ALGO_HDR;
                                        end
                                        PH_ALGO_HDR:
                                        begin
                                            ends_we[3] = 1'b1;
                                            phase_next = PH_OID_HDR;
                                        end
                                        default:
                                        begin
                                            ends_we[5] = 1'b1;
                                            phase_next = PH_N_HDR;
                                        end
                                    endcase
                                end
                            end
                            PH_TBS_FIRST, PH_SKIP_HDR:
                            begin
                                sk = skip_reg;
                                if (phase_reg == PH_TBS_FIRST)
                                    sk = (tag_next == TAG_VERSION) ? 3'd6 : 3'd5;
                                skip_next = sk;
                                elem_next = vend[31:0];
                                phase_next = PH_SKIP_BODY;
                                if (acc_next == 32'd0)
                                begin
                                    sk = (sk != 3'd0) ? sk - 3'd1 : 3'd0;
                                    skip_next = sk;
                                    phase_next = (sk == 3'd0) ? PH_SPKI_HDR : PH_SKIP_HDR;
                                end
                            end
                            PH_OID_HDR, PH_PARAM_HDR:
                            begin
                                if (tag_next != TAG_OID) fault = 1'b1;
                                else
                                begin
                                    oidx_next = '0;
                                    elem_next = vend[31:0];
                                    if (phase_reg == PH_OID_HDR)
                                    begin
                                        flags_next = '0;
                                        flags_next[CAND_EC] = (acc_next == 32'd7);
                                        flags_next[CAND_RSA] = (acc_next == 32'd9);
                                        phase_next = PH_OID_BODY;
                                    end
                                    else
                                    begin
                                        flags_next = '0;
                                        flags_next[CAND_P256] = (acc_next == 32'd8);
                                        phase_next = PH_PARAM_BODY;
                                    end
                                    if (acc_next == 32'd0) fault = 1'b1;
                                end
                            end
                            PH_BITS_HDR:
                            begin
                                if (tag_next != TAG_BITS || acc_next == 32'd0 ||
                                    (kind_reg == KIND_EC && acc_next != EC_BITS_LEN))
                                    fault = 1'b1;
                                else
                                begin
                                    ends_we[4] = 1'b1;
                                    phase_next = PH_BITS_UNUSED;
                                end
                            end
                            PH_N_HDR, PH_E_HDR:
                            begin
                                if (tag_next != TAG_INT || acc_next == 32'd0) fault = 1'b1;
                                else
                                begin
                                    elem_next = vend[31:0];
                                    first_next = 1'b1;
                                    phase_next = (phase_reg == PH_N_HDR) ? PH_N_BODY : PH_E_BODY;
                                end
                            end
                            default: fault = 1'b1;
                        endcase
                    end
                end
            end
        endcase

        if (fault)
        begin
            rej_next = 1'b1;
            phase_next = PH_FAIL;
        end

        if (phase_next == PH_DONE && !rej_next && {1'b0, ends_reg[0]} <= nxt)
            verd = (kind_next == KIND_EC) ? VERD_P256 :
                   ((kind_next == KIND_RSA) ? VERD_RSA : VERD_REJ);

        res.first = '{part: emit_part, key_byte: b, verdict: VERD_P256,
                      end_of_run: !item.is_last};
        res.second = '{part: PART_VERDICT, key_byte: 8'd0, verdict: verd, end_of_run: 1'b1};
        if (!accept) res.count = 2'd0;
        else res.count = 2'(emit) + 2'(item.is_last);
        if (!emit) res.first = res.second;

        if (item.is_last)
        begin
            phase_next = PH_CERT_HDR;
            pos_next = '0;
            tag_next = '0;
            acc_next = '0;
            left_next = '0;
            skip_next = '0;
            flags_next = '1;
            oidx_next = '0;
            kind_next = KIND_NONE;
            first_next = 1'b1;
            rej_next = 1'b0;
            hstage_next = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elem_reg <= elem_next;
            for (int i = 0; i < 6; i++)
            begin
                if (ends_we[i]) ends_reg[i] <= vend[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CERT_HDR;
            pos_reg <= '0;
            tag_reg <= '0;
            acc_reg <= '0;
            left_reg <= '0;
            skip_reg <= '0;
            flags_reg <= '1;
            oidx_reg <= '0;
            kind_reg <= KIND_NONE;
            first_reg <= 1'b1;
            rej_reg <= 1'b0;
            hstage_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            tag_reg <= tag_next;
            acc_reg <= acc_next;
            left_reg <= left_next;
            skip_reg <= skip_next;
            flags_reg <= flags_next;
            oidx_reg <= oidx_next;
            kind_reg <= kind_next;
            first_reg <= first_next;
            rej_reg <= rej_next;
            hstage_reg <= hstage_next;
        end
    end

endmodule

// ----- src/ckx_out_fifo.sv -----
module ckx_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  ckx_pkg::res_pair_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output ckx_pkg::out_item_t out_item
);
    import ckx_pkg::*;

    out_item_t   mem [4];
    logic [1:0]  wptr_reg, rptr_reg;
    logic [2:0]  cnt_reg;
    logic        pop;

    assign room = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_item = mem[rptr_reg];
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) mem[wptr_reg] <= push.first;
        if (push.count == 2'd2) mem[wptr_reg + 2'd1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + push.count;
            if (pop) rptr_reg <= rptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, push.count} - {2'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("result queue count out of range");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("results pushed without room");
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> cnt_reg == $past(cnt_reg) - 3'd1)
        else $error("queue count did not drop on pop");
`endif

endmodule

// ----- src/cert_public_key_extractor.sv -----
// Each request moves one certificate byte; one byte is taken per cycle while the result queue has room.
// Results are registered in a four-entry result queue when the byte is taken.
// Bytes are held off only while three or more results wait in the queue.
// Asynchronous active-low reset returns the parser to the certificate tag and empties the queue.
module cert_public_key_extractor #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    ckx_chan_if.sink   din,
    ckx_chan_if.source dout
);
    import ckx_pkg::*;

    res_pair_t res;
    logic      room;
    logic      accept;

    assign din.ready = room;
    assign accept = din.valid && room;

    ckx_parser #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (din.payload),
        .res    (res)
    );

    ckx_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .room      (room),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .out_item  (dout.payload)
    );

endmodule
